[sv/nec_ir_frame_decoder_assert.svh]
// Assertion macros shared by the checker of the NEC infrared frame decoder
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define NECIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("necir assertion failed");

// next-cycle implication, disabled while reset is asserted
`define NECIR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("necir assertion failed");

`endif

[sv/necir_pkg.sv]
// Package: types, constants and reset values of the NEC infrared frame decoder
`timescale 1ns / 1ps
`default_nettype none

package necir_pkg;

  localparam int TicksW        = 15;
  localparam int TolW          = 12;
  localparam int FieldW        = 16;
  localparam int MaxSymbols    = 64;
  localparam int CountW        = $clog2(MaxSymbols);
  localparam int FrameSymbols  = 34;
  localparam int RepeatSymbols = 2;
  localparam int CfgIdxW       = 4;
  localparam int CfgDataW      = 16;
  localparam int StatusW       = 2;

  localparam logic [TolW-1:0]   TolRst         = TolW'(200);
  localparam logic [TicksW-1:0] LeaderMarkRst  = TicksW'(9000);
  localparam logic [TicksW-1:0] LeaderSpaceRst = TicksW'(4500);
  localparam logic [TicksW-1:0] RepeatSpaceRst = TicksW'(2250);
  localparam logic [TicksW-1:0] ZeroMarkRst    = TicksW'(560);
  localparam logic [TicksW-1:0] ZeroSpaceRst   = TicksW'(560);
  localparam logic [TicksW-1:0] OneMarkRst     = TicksW'(560);
  localparam logic [TicksW-1:0] OneSpaceRst    = TicksW'(1690);

  typedef enum logic [StatusW-1:0] {
    ST_FRAME   = 2'd0,
    ST_REPEAT  = 2'd1,
    ST_REJECT  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOLERANCE    = 4'd0,
    CFG_LEADER_MARK  = 4'd1,
    CFG_LEADER_SPACE = 4'd2,
    CFG_REPEAT_SPACE = 4'd3,
    CFG_ZERO_MARK    = 4'd4,
    CFG_ZERO_SPACE   = 4'd5,
    CFG_ONE_MARK     = 4'd6,
    CFG_ONE_SPACE    = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [TolW-1:0]   tolerance;
    logic [TicksW-1:0] leader_mark;
    logic [TicksW-1:0] leader_space;
    logic [TicksW-1:0] repeat_space;
    logic [TicksW-1:0] zero_mark;
    logic [TicksW-1:0] zero_space;
    logic [TicksW-1:0] one_mark;
    logic [TicksW-1:0] one_space;
  } cfg_t;

  typedef struct packed {
    logic [TicksW-1:0] mark_ticks;
    logic [TicksW-1:0] space_ticks;
    logic              burst_end;
  } sym_t;

  typedef struct packed {
    logic is_leader;
    logic is_repeat;
    logic is_one;
    logic is_zero;
  } sym_class_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] address;
    logic [FieldW-1:0] command;
  } res_t;

endpackage

`default_nettype wire

[sv/necir_if.sv]
// Channel interfaces: symbol input, result output and configuration write
`timescale 1ns / 1ps
`default_nettype none

interface necir_sym_if;
  logic                           valid;
  logic                           ready;
  logic [necir_pkg::TicksW-1:0]   mark_ticks;
  logic [necir_pkg::TicksW-1:0]   space_ticks;
  logic                           burst_end;

  modport source (output valid, mark_ticks, space_ticks, burst_end, input ready);
  modport sink   (input valid, mark_ticks, space_ticks, burst_end, output ready);
endinterface

interface necir_res_if;
  logic                           valid;
  logic                           ready;
  logic [necir_pkg::StatusW-1:0]  status;
  logic [necir_pkg::FieldW-1:0]   address;
  logic [necir_pkg::FieldW-1:0]   command;

  modport source (output valid, status, address, command, input ready);
  modport sink   (input valid, status, address, command, output ready);
endinterface

interface necir_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [necir_pkg::CfgIdxW-1:0]  index;
  logic [necir_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/necir_cfg_regs.sv]
// Configuration register bank of the NEC infrared frame decoder
`timescale 1ns / 1ps
`default_nettype none

module necir_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [necir_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [necir_pkg::CfgDataW-1:0] wr_data_i,
  output necir_pkg::cfg_t                     cfg_o
);
  import necir_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_TOLERANCE:    cfg_d.tolerance    = wr_data_i[TolW-1:0];
        CFG_LEADER_MARK:  cfg_d.leader_mark  = wr_data_i[TicksW-1:0];
        CFG_LEADER_SPACE: cfg_d.leader_space = wr_data_i[TicksW-1:0];
        CFG_REPEAT_SPACE: cfg_d.repeat_space = wr_data_i[TicksW-1:0];
        CFG_ZERO_MARK:    cfg_d.zero_mark    = wr_data_i[TicksW-1:0];
        CFG_ZERO_SPACE:   cfg_d.zero_space   = wr_data_i[TicksW-1:0];
        CFG_ONE_MARK:     cfg_d.one_mark     = wr_data_i[TicksW-1:0];
        CFG_ONE_SPACE:    cfg_d.one_space    = wr_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance    <= TolRst;
      cfg_q.leader_mark  <= LeaderMarkRst;
      cfg_q.leader_space <= LeaderSpaceRst;
      cfg_q.repeat_space <= RepeatSpaceRst;
      cfg_q.zero_mark    <= ZeroMarkRst;
      cfg_q.zero_space   <= ZeroSpaceRst;
      cfg_q.one_mark     <= OneMarkRst;
      cfg_q.one_space    <= OneSpaceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/necir_sym_classify.sv]
// Symbol classifier: tolerance window checks of mark and space durations
`timescale 1ns / 1ps
`default_nettype none

module necir_sym_classify (
  input  wire necir_pkg::cfg_t              cfg_i,
  input  wire logic [necir_pkg::TicksW-1:0] mark_i,
  input  wire logic [necir_pkg::TicksW-1:0] space_i,
  output necir_pkg::sym_class_t             cls_o
);
  import necir_pkg::*;

  // strictly inside nominal +/- tol; a negative lower bound always passes
  function automatic logic in_window(logic [TicksW-1:0] ticks, logic [TicksW-1:0] nominal,
                                     logic [TolW-1:0] tol);
    logic [TicksW:0] hi;
    logic [TicksW:0] lo;
    logic            upper;
    logic            lower;
    hi    = {1'b0, nominal} + {{(TicksW+1-TolW){1'b0}}, tol};
    lo    = {1'b0, nominal} - {{(TicksW+1-TolW){1'b0}}, tol};
    upper = {1'b0, ticks} < hi;
    lower = lo[TicksW] || (ticks > lo[TicksW-1:0]);
    return upper && lower;
  endfunction

  logic mark_leader, mark_zero, mark_one;
  logic space_leader, space_repeat, space_zero, space_one;

  assign mark_leader  = in_window(mark_i,  cfg_i.leader_mark,  cfg_i.tolerance);
  assign mark_zero    = in_window(mark_i,  cfg_i.zero_mark,    cfg_i.tolerance);
  assign mark_one     = in_window(mark_i,  cfg_i.one_mark,     cfg_i.tolerance);
  assign space_leader = in_window(space_i, cfg_i.leader_space, cfg_i.tolerance);
  assign space_repeat = in_window(space_i, cfg_i.repeat_space, cfg_i.tolerance);
  assign space_zero   = in_window(space_i, cfg_i.zero_space,   cfg_i.tolerance);
  assign space_one    = in_window(space_i, cfg_i.one_space,    cfg_i.tolerance);

  assign cls_o.is_leader = mark_leader && space_leader;
  assign cls_o.is_repeat = mark_leader && space_repeat;
  assign cls_o.is_one    = mark_one && space_one;
  assign cls_o.is_zero   = mark_zero && space_zero;

endmodule

`default_nettype wire

[sv/necir_decode.sv]
// Burst decoder: symbol count, shift registers, saved values and result register
`timescale 1ns / 1ps
`default_nettype none

module necir_decode (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  burst_end_i,
  input  wire necir_pkg::sym_class_t cls_i,
  input  wire logic                  res_ready_i,
  output logic                       res_valid_o,
  output necir_pkg::res_t            res_o
);
  import necir_pkg::*;

  localparam logic [CountW-1:0] MaxCount    = CountW'(MaxSymbols - 1);
  localparam logic [CountW-1:0] AddrLastIdx = CountW'(FieldW);
  localparam logic [CountW-1:0] CmdLastIdx  = CountW'(2 * FieldW);
  localparam logic [CountW-1:0] FrameCount  = CountW'(FrameSymbols);
  localparam logic [CountW-1:0] RepeatCount = CountW'(RepeatSymbols);

  logic [CountW-1:0] count_q, count_d, count_nx;
  logic [FieldW-1:0] addr_q, addr_d, cmd_q, cmd_d;
  logic [FieldW-1:0] saved_addr_q, saved_addr_d, saved_cmd_q, saved_cmd_d;
  logic              frame_good_q, frame_good_d, repeat_good_q, repeat_good_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  always_comb begin
    count_d       = count_q;
    addr_d        = addr_q;
    cmd_d         = cmd_q;
    frame_good_d  = frame_good_q;
    repeat_good_d = repeat_good_q;
    saved_addr_d  = saved_addr_q;
    saved_cmd_d   = saved_cmd_q;
    res_d         = res_q;
    res_valid_d   = res_valid_q && !res_ready_i;
    count_nx      = (count_q != MaxCount) ? count_q + CountW'(1) : count_q;

    if (step_i) begin
      if (count_q == '0) begin
        frame_good_d  = frame_good_q && cls_i.is_leader;
        repeat_good_d = cls_i.is_repeat;
      end else if (count_q <= CmdLastIdx) begin
        if (!cls_i.is_one && !cls_i.is_zero) begin
          frame_good_d = 1'b0;
        end
        if (count_q <= AddrLastIdx) begin
          addr_d = {cls_i.is_one, addr_q[FieldW-1:1]};
        end else begin
          cmd_d = {cls_i.is_one, cmd_q[FieldW-1:1]};
        end
      end
      count_d = count_nx;

      if (burst_end_i) begin
        res_valid_d   = 1'b1;
        res_d.status  = ST_UNKNOWN;
        res_d.address = '0;
        res_d.command = '0;
        if (count_nx == FrameCount) begin
          if (frame_good_d) begin
            saved_addr_d  = addr_d;
            saved_cmd_d   = cmd_d;
            res_d.status  = ST_FRAME;
            res_d.address = addr_d;
            res_d.command = cmd_d;
          end else begin
            res_d.status = ST_REJECT;
          end
        end else if (count_nx == RepeatCount) begin
          if (repeat_good_d) begin
            res_d.status  = ST_REPEAT;
            res_d.address = saved_addr_q;
            res_d.command = saved_cmd_q;
          end else begin
            res_d.status = ST_REJECT;
          end
        end
        count_d       = '0;
        addr_d        = '0;
        cmd_d         = '0;
        frame_good_d  = 1'b1;
        repeat_good_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      addr_q        <= '0;
      cmd_q         <= '0;
      frame_good_q  <= 1'b1;
      repeat_good_q <= 1'b0;
      saved_addr_q  <= '0;
      saved_cmd_q   <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      count_q       <= count_d;
      addr_q        <= addr_d;
      cmd_q         <= cmd_d;
      frame_good_q  <= frame_good_d;
      repeat_good_q <= repeat_good_d;
      saved_addr_q  <= saved_addr_d;
      saved_cmd_q   <= saved_cmd_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[sv/nec_ir_frame_decoder.sv]
// An accepted symbol sits in the input register; a burst end's result is then held in the result register.
// Throughput: one symbol per cycle; the input register holds a burst-end symbol
// only while the result register is full and not taken.
// Reset: timing registers return to nominal NEC values, burst state and saved
// address/command clear; no clearing pass, symbols taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_decoder (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  necir_cfg_if.sink   cfg_i,
  necir_sym_if.sink   sym_i,
  necir_res_if.source res_o
);
  import necir_pkg::*;

  cfg_t       cfg;
  sym_t       sym_q;
  logic       sym_valid_q;
  logic       step;
  sym_class_t cls;
  res_t       res;
  logic       res_valid;

  assign cfg_i.ready = 1'b1;

  necir_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // input register; a burst end waits only for a free result register
  assign step        = sym_valid_q && (!sym_q.burst_end || !res_valid || res_o.ready);
  assign sym_i.ready = !sym_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_valid_q <= 1'b0;
    end else if (sym_i.ready) begin
      sym_valid_q <= sym_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_i.ready && sym_i.valid) begin
      sym_q.mark_ticks  <= sym_i.mark_ticks;
      sym_q.space_ticks <= sym_i.space_ticks;
      sym_q.burst_end   <= sym_i.burst_end;
    end
  end

  necir_sym_classify u_classify (
    .cfg_i   (cfg),
    .mark_i  (sym_q.mark_ticks),
    .space_i (sym_q.space_ticks),
    .cls_o   (cls)
  );

  necir_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .burst_end_i (sym_q.burst_end),
    .cls_i       (cls),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign res_o.valid   = res_valid;
  assign res_o.status  = res.status;
  assign res_o.address = res.address;
  assign res_o.command = res.command;

endmodule

`default_nettype wire

[sv/necir_checker.sv]
// Port-level checker of the NEC infrared frame decoder and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "nec_ir_frame_decoder_assert.svh"

module necir_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          sym_valid,
  input wire logic                          sym_ready,
  input wire logic                          sym_burst_end,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [necir_pkg::StatusW-1:0] res_status,
  input wire logic [necir_pkg::FieldW-1:0]  res_address,
  input wire logic [necir_pkg::FieldW-1:0]  res_command
);
  import necir_pkg::*;

  logic                          sym_xact;
  logic                          sym_end_xact;
  logic                          res_stall;
  logic                          res_nodata;
  logic                          res_zero;
  logic [StatusW+2*FieldW-1:0]   res_payload;

  assign sym_xact     = sym_valid && sym_ready;
  assign sym_end_xact = sym_xact && sym_burst_end;
  assign res_stall    = res_valid && !res_ready;
  assign res_nodata   = res_valid && (res_status == ST_REJECT || res_status == ST_UNKNOWN);
  assign res_zero     = (res_address == '0) && (res_command == '0);
  assign res_payload  = {res_status, res_address, res_command};

  `NECIR_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_stall, res_valid && $stable(res_payload))
  `NECIR_ASSERT_IMP(a_nodata_zero, clk_i, rst_ni, res_nodata, res_zero)
  `NECIR_ASSERT_IMP(a_res_origin, clk_i, rst_ni, $rose(res_valid), $past(sym_end_xact, 2))
  `NECIR_ASSERT_IMP(a_no_stall_in, clk_i, rst_ni, !res_valid, sym_ready)

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .sym_valid     (sym_i.valid),
  .sym_ready     (sym_i.ready),
  .sym_burst_end (sym_i.burst_end),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .res_status    (res_o.status),
  .res_address   (res_o.address),
  .res_command   (res_o.command)
);

`default_nettype wire

[tb/nec_ir_frame_decoder_checker.sv]
// Checker: watches the decoder's channels, predicts each burst report and compares it
`timescale 1ns / 1ps

module nec_ir_frame_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  necir_cfg_if        cfg_i,
  necir_sym_if        sym_i,
  necir_res_if        res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import necir_pkg::*;

  cfg_t              timing;
  logic [CountW-1:0] sym_cnt;
  logic [FieldW-1:0] addr_sr;
  logic [FieldW-1:0] cmd_sr;
  logic [FieldW-1:0] saved_addr;
  logic [FieldW-1:0] saved_cmd;
  bit                frame_ok;
  bit                rep_ok;
  res_t              burst_reports_q[$];
  int unsigned       fails;
  int unsigned       reported;

  function automatic bit near_nominal(input int unsigned ticks, input int unsigned nom,
                                      input int unsigned tol);
    return (ticks < nom + tol) && ((nom < tol) || (ticks > nom - tol));
  endfunction

  function automatic bit sym_match(input int unsigned mark, input int unsigned space,
                                   input int unsigned nom_mark, input int unsigned nom_space,
                                   input int unsigned tol);
    return near_nominal(mark, nom_mark, tol) && near_nominal(space, nom_space, tol);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    res_t        got;
    int unsigned mark;
    int unsigned space;
    int unsigned tol;
    bit          is_one;
    if (!rst_ni) begin
      timing.tolerance    = TolRst;
      timing.leader_mark  = LeaderMarkRst;
      timing.leader_space = LeaderSpaceRst;
      timing.repeat_space = RepeatSpaceRst;
      timing.zero_mark    = ZeroMarkRst;
      timing.zero_space   = ZeroSpaceRst;
      timing.one_mark     = OneMarkRst;
      timing.one_space    = OneSpaceRst;
      sym_cnt    = '0;
      addr_sr    = '0;
      cmd_sr     = '0;
      frame_ok   = 1'b1;
      rep_ok     = 1'b0;
      saved_addr = '0;
      saved_cmd  = '0;
      burst_reports_q.delete();
      fails      = 0;
      reported   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_TOLERANCE:    timing.tolerance    = cfg_i.data[TolW-1:0];
          CFG_LEADER_MARK:  timing.leader_mark  = cfg_i.data[TicksW-1:0];
          CFG_LEADER_SPACE: timing.leader_space = cfg_i.data[TicksW-1:0];
          CFG_REPEAT_SPACE: timing.repeat_space = cfg_i.data[TicksW-1:0];
          CFG_ZERO_MARK:    timing.zero_mark    = cfg_i.data[TicksW-1:0];
          CFG_ZERO_SPACE:   timing.zero_space   = cfg_i.data[TicksW-1:0];
          CFG_ONE_MARK:     timing.one_mark     = cfg_i.data[TicksW-1:0];
          CFG_ONE_SPACE:    timing.one_space    = cfg_i.data[TicksW-1:0];
          default: ;
        endcase
      end

      if (sym_i.valid && sym_i.ready) begin
        mark  = sym_i.mark_ticks;
        space = sym_i.space_ticks;
        tol   = timing.tolerance;
        if (sym_cnt == 0) begin
          frame_ok = frame_ok &&
                     sym_match(mark, space, timing.leader_mark, timing.leader_space, tol);
          rep_ok   = sym_match(mark, space, timing.leader_mark, timing.repeat_space, tol);
        end else if (sym_cnt <= 2 * FieldW) begin
          // a symbol that fits both bit shapes counts as a one
          is_one = sym_match(mark, space, timing.one_mark, timing.one_space, tol);
          if (!is_one && !sym_match(mark, space, timing.zero_mark, timing.zero_space, tol))
            frame_ok = 1'b0;
          if (sym_cnt <= FieldW)
            addr_sr = {is_one, addr_sr[FieldW-1:1]};
          else
            cmd_sr = {is_one, cmd_sr[FieldW-1:1]};
        end
        if (sym_cnt < MaxSymbols - 1)
          sym_cnt = sym_cnt + 1'b1;

        if (sym_i.burst_end) begin
          want.status  = ST_UNKNOWN;
          want.address = '0;
          want.command = '0;
          if (sym_cnt == FrameSymbols) begin
            if (frame_ok) begin
              saved_addr   = addr_sr;
              saved_cmd    = cmd_sr;
              want.status  = ST_FRAME;
              want.address = saved_addr;
              want.command = saved_cmd;
            end else begin
              want.status = ST_REJECT;
            end
          end else if (sym_cnt == RepeatSymbols) begin
            if (rep_ok) begin
              want.status  = ST_REPEAT;
              want.address = saved_addr;
              want.command = saved_cmd;
            end else begin
              want.status = ST_REJECT;
            end
          end
          burst_reports_q.push_back(want);
          sym_cnt  = '0;
          addr_sr  = '0;
          cmd_sr   = '0;
          frame_ok = 1'b1;
          rep_ok   = 1'b0;
        end
      end

      if (res_i.valid && res_i.ready) begin
        got.status  = status_e'(res_i.status);
        got.address = res_i.address;
        got.command = res_i.command;
        if (burst_reports_q.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected report status=%0d addr=%h cmd=%h", $realtime,
                     got.status, got.address, got.command);
          end
        end else begin
          want = burst_reports_q.pop_front();
          if (got.status !== want.status || got.address !== want.address ||
              got.command !== want.command) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display({"%0t: report mismatch exp status=%0d addr=%h cmd=%h,",
                        " got status=%0d addr=%h cmd=%h"},
                       $realtime, want.status, want.address, want.command,
                       got.status, got.address, got.command);
            end
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= burst_reports_q.size();
    end
  end

endmodule

[tb/nec_ir_frame_decoder_tb.sv]
// Testbench top: clock, reset, symbol and timing stimulus, and verdict for the decoder
`timescale 1ns / 1ps

module nec_ir_frame_decoder_tb;
  import necir_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned TotalSymbols = 1750;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseSymbols = TotalSymbols / NumPhases;
  localparam int unsigned PhaseBursts  = 8;
  localparam int unsigned TicksMax     = (1 << TicksW) - 1;

  typedef enum int {BK_FRAME, BK_BROKEN, BK_REPEAT, BK_ODD_LEN, BK_NOISE} burst_kind_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  int unsigned sent_syms;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  cfg_t        cur_cfg;

  necir_cfg_if cfg_if ();
  necir_sym_if sym_if ();
  necir_res_if res_if ();

  nec_ir_frame_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .sym_i  (sym_if),
    .res_o  (res_if)
  );

  nec_ir_frame_decoder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .sym_i        (sym_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni)
      res_if.ready <= 1'b0;
    else
      res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic cfg_t nec_timing();
    cfg_t c;
    c.tolerance    = TolRst;
    c.leader_mark  = LeaderMarkRst;
    c.leader_space = LeaderSpaceRst;
    c.repeat_space = RepeatSpaceRst;
    c.zero_mark    = ZeroMarkRst;
    c.zero_space   = ZeroSpaceRst;
    c.one_mark     = OneMarkRst;
    c.one_space    = OneSpaceRst;
    return c;
  endfunction

  function automatic cfg_t phase_timing(input int unsigned phase);
    cfg_t c;
    c = nec_timing();
    case (phase)
      1: c.tolerance = TolW'($urandom_range(600, 50));
      2: begin
        // wide tolerance: bit shapes overlap and lower bounds go negative
        c.tolerance    = '1;
        c.leader_mark  = TicksW'($urandom_range(3000));
        c.leader_space = TicksW'($urandom_range(3000));
        c.repeat_space = TicksW'($urandom_range(3000));
        c.zero_mark    = TicksW'($urandom_range(3000));
        c.zero_space   = TicksW'($urandom_range(3000));
        c.one_mark     = TicksW'($urandom_range(3000));
        c.one_space    = TicksW'($urandom_range(3000));
      end
      3: begin
        c.tolerance    = TolW'($urandom_range(4095, 1));
        c.leader_mark  = '1;
        c.leader_space = '1;
        c.repeat_space = '1;
        c.zero_mark    = '1;
        c.zero_space   = '1;
        c.one_mark     = '1;
        c.one_space    = '1;
      end
      4: begin
        c.tolerance    = TolW'($urandom_range(4095, 1));
        c.leader_mark  = '0;
        c.leader_space = '0;
        c.repeat_space = '0;
        c.zero_mark    = '0;
        c.zero_space   = '0;
        c.one_mark     = '0;
        c.one_space    = '0;
      end
      5: c.tolerance = '0;
      6: begin
        c.tolerance    = TolW'($urandom);
        c.leader_mark  = TicksW'($urandom);
        c.leader_space = TicksW'($urandom);
        c.repeat_space = TicksW'($urandom);
        c.zero_mark    = TicksW'($urandom);
        c.zero_space   = TicksW'($urandom);
        c.one_mark     = TicksW'($urandom);
        c.one_space    = TicksW'($urandom);
      end
      default: begin
        c.tolerance    = TolW'($urandom_range(400, 100));
        c.leader_mark  = TicksW'($urandom_range(12000, 300));
        c.leader_space = TicksW'($urandom_range(12000, 300));
        c.repeat_space = TicksW'($urandom_range(12000, 300));
        c.zero_mark    = TicksW'($urandom_range(12000, 300));
        c.zero_space   = TicksW'($urandom_range(12000, 300));
        c.one_mark     = TicksW'($urandom_range(12000, 300));
        c.one_space    = TicksW'($urandom_range(12000, 300));
      end
    endcase
    return c;
  endfunction

  // good aims inside the open window around nom, bad at its edges; some picks are random
  function automatic logic [TicksW-1:0] pick_ticks(input int unsigned nom, input bit good);
    int unsigned tol;
    int unsigned lo;
    int unsigned hi;
    tol = cur_cfg.tolerance;
    hi  = nom + tol;
    if (hi > TicksMax)
      hi = TicksMax;
    if ($urandom_range(19) == 0)
      return TicksW'($urandom);
    if (!good) begin
      case ($urandom_range(3))
        0: return TicksW'(hi);
        1: return TicksW'((nom < tol) ? 0 : nom - tol);
        default: return TicksW'($urandom);
      endcase
    end
    if (tol == 0)
      return TicksW'(nom);
    lo = (nom < tol) ? 0 : nom - tol + 1;
    hi = nom + tol - 1;
    if (hi > TicksMax)
      hi = TicksMax;
    case ($urandom_range(3))
      0: return TicksW'(lo);
      1: return TicksW'(hi);
      default: return TicksW'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic send_sym(input logic [TicksW-1:0] mark, input logic [TicksW-1:0] space,
                          input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      sym_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sym_if.valid       <= 1'b1;
    sym_if.mark_ticks  <= mark;
    sym_if.space_ticks <= space;
    sym_if.burst_end   <= last;
    do @(posedge clk_i); while (!sym_if.ready);
    sent_syms++;
    if (sent_syms < TotalSymbols / 3) begin
      tx_idle_pct  = 38;
      rx_stall_pct = 66;
    end else if (sent_syms < 2 * TotalSymbols / 3) begin
      tx_idle_pct  = 66;
      rx_stall_pct = 38;
    end else begin
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
    end
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // bits above each register's width are random and must be dropped
  task automatic load_timing(input cfg_t c);
    put_reg(CfgIdxW'($urandom_range(15, 8)), CfgDataW'($urandom));
    put_reg(CFG_TOLERANCE,    {4'($urandom), c.tolerance});
    put_reg(CFG_LEADER_MARK,  {1'($urandom), c.leader_mark});
    put_reg(CFG_LEADER_SPACE, {1'($urandom), c.leader_space});
    put_reg(CFG_REPEAT_SPACE, {1'($urandom), c.repeat_space});
    put_reg(CFG_ZERO_MARK,    {1'($urandom), c.zero_mark});
    put_reg(CFG_ZERO_SPACE,   {1'($urandom), c.zero_space});
    put_reg(CFG_ONE_MARK,     {1'($urandom), c.one_mark});
    put_reg(CFG_ONE_SPACE,    {1'($urandom), c.one_space});
    cfg_if.valid <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic drain();
    sym_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_burst(input burst_kind_e kind);
    int unsigned len;
    int unsigned bad_at;
    int unsigned bad_sel;
    bit          one;
    bit          good_m;
    bit          good_s;
    bad_at  = (kind == BK_BROKEN) ? $urandom_range(FrameSymbols - 2) : FrameSymbols;
    bad_sel = $urandom_range(1);
    case (kind)
      BK_REPEAT: begin
        // now and then a leader shape, which must not pass as a repeat code
        if ($urandom_range(4) == 0)
          send_sym(pick_ticks(cur_cfg.leader_mark, 1'b1),
                   pick_ticks(cur_cfg.leader_space, 1'b1), 1'b0);
        else
          send_sym(pick_ticks(cur_cfg.leader_mark, $urandom_range(7) != 0),
                   pick_ticks(cur_cfg.repeat_space, $urandom_range(7) != 0), 1'b0);
        send_sym(TicksW'($urandom), TicksW'($urandom), 1'b1);
      end
      BK_NOISE: begin
        len = $urandom_range(6, 1);
        for (int n = 0; n < len; n++)
          send_sym(TicksW'($urandom), TicksW'($urandom), n == len - 1);
      end
      default: begin
        if (kind == BK_ODD_LEN) begin
          case ($urandom_range(7))
            0: len = 1;
            1: len = 3;
            2: len = FrameSymbols - 1;
            3: len = FrameSymbols + 1;
            4: len = MaxSymbols - 1;
            5: len = MaxSymbols;
            default: len = $urandom_range(MaxSymbols + 8, FrameSymbols + 2);
          endcase
        end else begin
          len = FrameSymbols;
        end
        for (int n = 0; n < len; n++) begin
          good_m = !(n == bad_at && bad_sel == 0);
          good_s = !(n == bad_at && bad_sel == 1);
          one    = $urandom_range(1);
          if (n == 0)
            send_sym(pick_ticks(cur_cfg.leader_mark, good_m),
                     pick_ticks(cur_cfg.leader_space, good_s), n == len - 1);
          else if (n <= 2 * FieldW && one)
            send_sym(pick_ticks(cur_cfg.one_mark, good_m),
                     pick_ticks(cur_cfg.one_space, good_s), n == len - 1);
          else if (n <= 2 * FieldW)
            send_sym(pick_ticks(cur_cfg.zero_mark, good_m),
                     pick_ticks(cur_cfg.zero_space, good_s), n == len - 1);
          else
            send_sym(TicksW'($urandom), TicksW'($urandom), n == len - 1);
        end
      end
    endcase
  endtask

  task automatic run_random_phase();
    int unsigned start_syms;
    int unsigned bursts;
    int unsigned pick;
    start_syms = sent_syms;
    bursts     = 0;
    while (sent_syms - start_syms < PhaseSymbols || bursts < PhaseBursts) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_burst(BK_FRAME);
      else if (pick < 60)
        send_burst(BK_BROKEN);
      else if (pick < 80)
        send_burst(BK_REPEAT);
      else if (pick < 90)
        send_burst(BK_ODD_LEN);
      else
        send_burst(BK_NOISE);
      bursts++;
    end
  endtask

  task automatic run_directed();
    // repeat before any frame reports the cleared saved values
    send_sym(LeaderMarkRst, RepeatSpaceRst, 1'b0);
    send_sym('0, '0, 1'b1);
    // lone symbol at full scale
    send_sym('1, '1, 1'b1);
    // just inside both window edges
    send_sym(TicksW'(LeaderMarkRst + TolRst - 1), TicksW'(RepeatSpaceRst - TolRst + 1), 1'b0);
    send_sym('1, '0, 1'b1);
    // on the upper edge
    send_sym(TicksW'(LeaderMarkRst + TolRst), RepeatSpaceRst, 1'b0);
    send_sym('0, '1, 1'b1);
    // on the lower edge
    send_sym(TicksW'(LeaderMarkRst - TolRst), RepeatSpaceRst, 1'b0);
    send_sym(TicksW'(1), TicksW'(1), 1'b1);
    // leader where a repeat code belongs
    send_sym(LeaderMarkRst, LeaderSpaceRst, 1'b0);
    send_sym(ZeroMarkRst, ZeroSpaceRst, 1'b1);
    // three symbols
    send_sym(LeaderMarkRst, RepeatSpaceRst, 1'b0);
    send_sym(ZeroMarkRst, ZeroSpaceRst, 1'b0);
    send_sym(OneMarkRst, OneSpaceRst, 1'b1);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    sym_if.valid       <= 1'b0;
    sym_if.mark_ticks  <= '0;
    sym_if.space_ticks <= '0;
    sym_if.burst_end   <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_TOLERANCE;
    cfg_if.data        <= '0;
    sent_syms    = 0;
    tx_idle_pct  = 38;
    rx_stall_pct = 66;
    cur_cfg      = nec_timing();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        drain();
        load_timing(phase_timing(phase));
      end
      run_random_phase();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
